// ----- rtl/gbia_pkg.sv -----
`default_nettype none

package gbia_pkg;

  // Width of the configuration write data (active group count)
  localparam int unsigned CFG_W = 5;
  // Width of one bitmap word and of a bit index inside it
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_W     = 6;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_DOUBLE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [11:0] request_value;
  } req_t;

  typedef struct packed {
    logic [11:0] granted_value;
    status_e     status;
    logic [12:0] free_remaining;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/grouped_bitmap_id_allocator.sv -----
`default_nettype none

// Steps: an allocate scans the head group's words in ST_SCAN, then goes to ST_WRITE and
//   ST_RESP; a good free does the same, a double free skips ST_WRITE, and nothing free
//   or out of range goes straight to ST_RESP, which registers the result.
// Throughput: one request at a time; a stalled result holds the next input.
// Reset: every value free, groups queued in ascending order, 16 groups active (clamped
//   to MAX_GROUPS). A config write does the same at once but with the written group count.
module grouped_bitmap_id_allocator
  import gbia_pkg::*;
#(
  parameter int unsigned GROUP_SIZE = 256,  // power of two, 64 .. 1024
  parameter int unsigned MAX_GROUPS = 16    // 1 .. 128
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  // request channel
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire req_t        in_data_i,
  // result channel
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output rsp_t             out_data_o,
  // configuration write channel: active group count
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire [CFG_W-1:0]  cfg_data_i
);

  // Geometry of the store
  localparam int unsigned WPG     = GROUP_SIZE / WORD_BITS;        // words per group
  localparam int unsigned WORDS   = WPG * MAX_GROUPS;
  localparam int unsigned GS_SH   = $clog2(GROUP_SIZE);
  localparam int unsigned GW      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned WIW     = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int unsigned AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned FW      = $clog2(MAX_GROUPS + 1);
  localparam int unsigned CW      = $clog2(GROUP_SIZE + 1);
  localparam int unsigned TW      = $clog2(MAX_GROUPS * GROUP_SIZE + 1);
  localparam int unsigned RST_ACT = (MAX_GROUPS < 16) ? MAX_GROUPS : 16;

  // Control state
  state_e                  state_q, state_d;
  logic [FW-1:0]           active_q;
  logic [FW-1:0]           fill_q;
  logic [GW-1:0]           head_q;
  logic [TW-1:0]           free_total_q;
  logic [CW-1:0]           cnt_q   [MAX_GROUPS];
  logic [GW-1:0]           queue_q [MAX_GROUPS];
  logic [WORDS-1:0]        wvalid_q;
  logic                    out_valid_q;

  // Per-request working registers
  mode_e                   mode_q;
  logic [GW-1:0]           grp_q;
  logic [WIW-1:0]          wig_q;
  logic [BIT_W-1:0]        bit_q;
  logic [WORD_BITS-1:0]    wdata_q;
  status_e                 stat_q;
  logic [11:0]             grant_q;
  rsp_t                    out_q;

  // Bitmap memory and its read port
  logic [WORD_BITS-1:0]    mem [WORDS];
  logic [WORD_BITS-1:0]    rdata_q;
  logic                    rvalid_q;
  logic                    mem_re;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           waddr;
  logic                    mem_we;

  // Decoded request and helpers
  logic                    in_acc;
  logic                    cfg_we;
  logic                    out_free;
  logic                    empty;
  logic                    range_bad;
  logic [GW-1:0]           head_grp;
  logic [GW-1:0]           g_in;
  logic [WIW-1:0]          wig_in;
  logic [BIT_W-1:0]        bit_in;
  logic [WORD_BITS-1:0]    word;
  logic                    word_any;
  logic                    last_word;
  logic [BIT_W-1:0]        lsb;
  logic [FW-1:0]           act_new;
  logic [CW-1:0]           cnt_cur;
  logic [CW-1:0]           cnt_dec;
  logic [CW-1:0]           cnt_inc;
  logic [GW-1:0]           head_inc;
  logic [GW-1:0]           tail;
  logic [31:0]             tail_sum;
  logic [31:0]             cfg_val;
  logic [31:0]             tot32;

  // Lowest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  // The output register can take a new result when empty or drained this cycle
  assign out_free    = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  assign empty     = (free_total_q == '0) || (fill_q == '0);
  assign head_grp  = queue_q[head_q];
  assign range_bad = 32'(in_data_i.request_value) >= (32'(active_q) << GS_SH);
  assign g_in      = GW'(32'(in_data_i.request_value) >> GS_SH);
  assign wig_in    = (WPG > 1) ? WIW'(32'(in_data_i.request_value) >> BIT_W) : '0;
  assign bit_in    = in_data_i.request_value[BIT_W-1:0];

  // A word never written since the last reinitialisation reads as all free
  assign word      = rvalid_q ? rdata_q : '1;
  assign word_any  = |word;
  assign last_word = (wig_q == WIW'(WPG - 1));
  assign lsb       = lowest_set(word);

  // Clamp the written group count into 1 .. MAX_GROUPS
  assign cfg_val = 32'(cfg_data_i);
  assign act_new = (cfg_val == 32'd0)       ? FW'(1) :
                   (cfg_val > MAX_GROUPS)   ? FW'(MAX_GROUPS) : FW'(cfg_val);

  // Counter and queue pointer arithmetic for the write-back step
  assign cnt_cur  = cnt_q[grp_q];
  assign cnt_dec  = (cnt_cur != '0) ? cnt_cur - CW'(1) : '0;
  assign cnt_inc  = cnt_cur + CW'(1);
  assign head_inc = (32'(head_q) == MAX_GROUPS - 1) ? '0 : head_q + GW'(1);
  assign tail_sum = 32'(head_q) + 32'(fill_q);
  assign tail     = (tail_sum >= MAX_GROUPS) ? GW'(tail_sum - MAX_GROUPS) : GW'(tail_sum);
  assign tot32    = 32'(free_total_q);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.mode == MODE_ALLOC) begin
            state_d = empty ? ST_RESP : ST_SCAN;
          end else begin
            state_d = range_bad ? ST_RESP : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (mode_q == MODE_ALLOC) begin
          if (word_any) begin
            state_d = ST_WRITE;
          end else if (last_word) begin
            state_d = ST_RESP;
          end
        end else begin
          state_d = word[bit_q] ? ST_RESP : ST_WRITE;
        end
      end
      ST_WRITE: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory port control
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_re = 1'b0;
    raddr  = AW'(32'(grp_q) * WPG + 32'(wig_q + WIW'(1)));
    waddr  = AW'(32'(grp_q) * WPG + 32'(wig_q));
    mem_we = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // Fetch the first word of the head group, or the word that holds the freed value
        mem_re = in_acc;
        if (in_data_i.mode == MODE_ALLOC) begin
          raddr = AW'(32'(head_grp) * WPG);
        end else begin
          raddr = AW'(32'(g_in) * WPG + 32'(wig_in));
        end
      end
      ST_SCAN: begin
        // Advance to the next word while the current one has nothing free
        mem_re = (mode_q == MODE_ALLOC) && !word_any && !last_word;
      end
      ST_WRITE: mem_we = 1'b1;
      ST_RESP:  mem_re = 1'b0;
      default:  mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata_q;
    end
    if (mem_re) begin
      rdata_q  <= mem[raddr];
      rvalid_q <= wvalid_q[raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control state: counts, queue, totals, output valid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      active_q     <= FW'(RST_ACT);
      fill_q       <= FW'(RST_ACT);
      head_q       <= '0;
      free_total_q <= TW'(RST_ACT * GROUP_SIZE);
      wvalid_q     <= '0;
      for (int g = 0; g < MAX_GROUPS; g++) begin
        cnt_q[g]   <= CW'(GROUP_SIZE);
        queue_q[g] <= GW'(g);
      end
    end else begin
      state_q <= state_d;

      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we) begin
        // Reinitialise: all values free, groups queued in ascending order
        active_q     <= act_new;
        fill_q       <= act_new;
        head_q       <= '0;
        free_total_q <= TW'(32'(act_new) << GS_SH);
        wvalid_q     <= '0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
          cnt_q[g]   <= CW'(GROUP_SIZE);
          queue_q[g] <= GW'(g);
        end
      end else if (state_q == ST_WRITE) begin
        wvalid_q[waddr] <= 1'b1;
        if (mode_q == MODE_ALLOC) begin
          cnt_q[grp_q] <= cnt_dec;
          free_total_q <= free_total_q - TW'(1);
          // Drop a group from the queue head once it is full
          if (cnt_dec == '0) begin
            head_q <= head_inc;
            fill_q <= fill_q - FW'(1);
          end
        end else begin
          cnt_q[grp_q] <= cnt_inc;
          free_total_q <= free_total_q + TW'(1);
          // A group that regains its first free value rejoins at the tail
          if (cnt_inc == CW'(1) && 32'(fill_q) < MAX_GROUPS) begin
            queue_q[tail] <= grp_q;
            fill_q        <= fill_q + FW'(1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers for the request in flight
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mode_q  <= in_data_i.mode;
          grant_q <= '0;
          stat_q  <= STAT_OK;
          if (in_data_i.mode == MODE_ALLOC) begin
            grp_q <= head_grp;
            wig_q <= '0;
            if (empty) begin
              stat_q <= STAT_EMPTY;
            end
          end else begin
            grp_q <= g_in;
            wig_q <= wig_in;
            bit_q <= bit_in;
            if (range_bad) begin
              stat_q <= STAT_RANGE;
            end
          end
        end
      end
      ST_SCAN: begin
        if (mode_q == MODE_ALLOC) begin
          if (word_any) begin
            wdata_q <= word & ~(WORD_BITS'(1) << lsb);
            grant_q <= 12'((32'(grp_q) << GS_SH) + (32'(wig_q) << BIT_W) + 32'(lsb));
          end else if (last_word) begin
            stat_q <= STAT_EMPTY;
          end else begin
            wig_q <= wig_q + WIW'(1);
          end
        end else begin
          if (word[bit_q]) begin
            stat_q <= STAT_DOUBLE;
          end else begin
            wdata_q <= word | (WORD_BITS'(1) << bit_q);
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_q.granted_value  <= grant_q;
          out_q.status         <= stat_q;
          out_q.free_remaining <= tot32[12:0];
        end
      end
      ST_WRITE: begin
        grant_q <= grant_q;
      end
      default: begin
        grant_q <= grant_q;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= MAX_GROUPS)
    else $error("queue fill exceeds group count");

  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot32 <= (32'(active_q) << GS_SH))
    else $error("free total exceeds active value space");

  a_alloc_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && mode_q == MODE_ALLOC && !cfg_we)
      |=> (free_total_q == $past(free_total_q) - TW'(1)))
    else $error("allocate write-back did not take one value");

  a_free_inc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && mode_q == MODE_FREE && !cfg_we)
      |=> (free_total_q == $past(free_total_q) + TW'(1)))
    else $error("free write-back did not return one value");

  a_out_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_RESP))
    else $error("result presented outside the response step");

endmodule

`default_nettype wire

// ----- tb/tb_grouped_bitmap_id_allocator.sv -----
`default_nettype none

module tb_grouped_bitmap_id_allocator;
  import gbia_pkg::*;

  // Run limit in clock cycles
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Length of the long receiver hold-off that backs the block up
  localparam int unsigned HOLD_CYCLES = 200;

  // Scoreboard: keeps its own copy of the value store, predicts the result of
  // every accepted request and checks the results in order.
  class id_pool_scoreboard;
    localparam int unsigned GRP_SIZE  = 256;
    localparam int unsigned GRP_MAX   = 16;
    localparam int unsigned GRP_WORDS = GRP_SIZE / 64;

    bit [63:0]   free_map [GRP_WORDS*GRP_MAX];
    int unsigned grp_free [GRP_MAX];
    int unsigned grp_fifo [GRP_MAX];
    int unsigned fifo_head;
    int unsigned fifo_fill;
    int unsigned free_total;
    int unsigned groups;
    rsp_t        expected_rsps[$];
    bit [11:0]   granted_ids[$];
    int unsigned errors;

    function new();
      errors = 0;
      reload(GRP_MAX);
    endfunction

    // Reinitialise the store: every value free, groups queued in ascending order
    function void reload(int unsigned g);
      if (g < 1) g = 1;
      if (g > GRP_MAX) g = GRP_MAX;
      groups = g;
      foreach (free_map[i]) free_map[i] = '1;
      for (int i = 0; i < GRP_MAX; i++) begin
        grp_free[i] = GRP_SIZE;
        grp_fifo[i] = i;
      end
      fifo_head  = 0;
      fifo_fill  = g;
      free_total = g * GRP_SIZE;
      granted_ids.delete();
    endfunction

    function void note_request(req_t r);
      rsp_t        e;
      int unsigned g;
      int unsigned off;
      int unsigned wi;
      bit          found;
      int          idx[$];
      e = '0;
      e.status = STAT_OK;
      if (r.mode == MODE_ALLOC) begin
        if (free_total == 0 || fifo_fill == 0) begin
          e.status = STAT_EMPTY;
        end else begin
          g = grp_fifo[fifo_head % GRP_MAX] % GRP_MAX;
          found = 1'b0;
          for (int w = 0; w < GRP_WORDS && !found; w++) begin
            for (int b = 0; b < 64 && !found; b++) begin
              if (free_map[g*GRP_WORDS + w][b]) begin
                free_map[g*GRP_WORDS + w][b] = 1'b0;
                e.granted_value = 12'(g*GRP_SIZE + w*64 + b);
                found = 1'b1;
              end
            end
          end
          if (!found) begin
            e.status = STAT_EMPTY;
          end else begin
            free_total--;
            if (grp_free[g] > 0) grp_free[g]--;
            // full group leaves the head of the queue
            if (grp_free[g] == 0) begin
              fifo_head = (fifo_head + 1) % GRP_MAX;
              fifo_fill--;
            end
            granted_ids.push_back(e.granted_value);
          end
        end
      end else begin
        if (r.request_value >= groups * GRP_SIZE) begin
          e.status = STAT_RANGE;
        end else begin
          g   = r.request_value / GRP_SIZE;
          off = r.request_value % GRP_SIZE;
          wi  = g*GRP_WORDS + off/64;
          if (free_map[wi][off%64]) begin
            e.status = STAT_DOUBLE;
          end else begin
            free_map[wi][off%64] = 1'b1;
            grp_free[g]++;
            free_total++;
            // group that was full rejoins at the tail
            if (grp_free[g] == 1 && fifo_fill < GRP_MAX) begin
              grp_fifo[(fifo_head + fifo_fill) % GRP_MAX] = g;
              fifo_fill++;
            end
            idx = granted_ids.find_first_index(item) with (item == r.request_value);
            if (idx.size() != 0) granted_ids.delete(idx[0]);
          end
        end
      end
      e.free_remaining = 13'(free_total);
      expected_rsps.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_rsps.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: granted %0d status %0d free %0d",
                   got.granted_value, got.status, got.free_remaining);
        return;
      end
      e = expected_rsps.pop_front();
      if (got.granted_value !== e.granted_value || got.status !== e.status ||
          got.free_remaining !== e.free_remaining) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: granted %0d/%0d status %0d/%0d free %0d/%0d (exp/got)",
                   e.granted_value, got.granted_value, e.status, got.status,
                   e.free_remaining, got.free_remaining);
      end
    endfunction

    function int unsigned pending();
      return expected_rsps.size();
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  req_t             in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  rsp_t             out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  id_pool_scoreboard sb = new();

  // Idle rates in percent per cycle, and the hold-off request for the receiver
  int unsigned send_idle   = 31;
  int unsigned recv_idle   = 60;
  int unsigned items_sent  = 0;
  int unsigned hold_left   = 0;
  bit          hold_request = 1'b0;

  grouped_bitmap_id_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: stall at random, or hold off for a long stretch when asked
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // Check every result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Give up if the run hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // Offer one request, idling first at the sender's rate; return once it has been
  // transferred, leaving valid high so that back-to-back requests need no gap.
  task automatic send_req(mode_e m, logic [11:0] v);
    req_t r;
    // swap the idle rates between sender and receiver, then drop idling altogether
    if (items_sent == 140) begin
      send_idle = 60;
      recv_idle = 31;
    end else if (items_sent == 280) begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    r.mode          = m;
    r.request_value = v;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    sb.note_request(r);
  endtask

  // Pause the sender until every outstanding result has come back
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write the active group count; only called with the block idle
  task automatic write_groups(logic [CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.reload(v);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: allocations and frees of values actually held,
  // with a share of frees of random values (double frees, out of range).
  task automatic rand_item(int unsigned alloc_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < alloc_pct)
      send_req(MODE_ALLOC, 12'($urandom));
    else if (roll < alloc_pct + (100 - alloc_pct)*4/5 && sb.granted_ids.size() != 0)
      send_req(MODE_FREE, sb.granted_ids[$urandom_range(sb.granted_ids.size() - 1)]);
    else
      send_req(MODE_FREE, 12'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state with all sixteen groups
    send_req(MODE_ALLOC, 12'hFFF);   // request value ignored on allocate
    send_req(MODE_ALLOC, 12'h000);
    send_req(MODE_ALLOC, 12'h000);
    send_req(MODE_FREE,  12'd1);
    send_req(MODE_FREE,  12'd1);     // double free
    send_req(MODE_FREE,  12'hFFF);   // last value, still free
    send_req(MODE_ALLOC, 12'h000);   // lowest free value again
    send_req(MODE_FREE,  12'd0);
    // hold the receiver off while the sender keeps offering
    hold_request = 1'b1;
    repeat (4) send_req(MODE_ALLOC, 12'($urandom));
    wait_results_drained();

    // zero counts as a single group
    write_groups(5'd0);
    send_req(MODE_FREE,  12'd256);   // just past the range
    send_req(MODE_FREE,  12'hFFF);   // far out of range
    send_req(MODE_FREE,  12'd255);   // double free at the top of the group
    send_req(MODE_ALLOC, 12'h000);
    send_req(MODE_FREE,  12'd0);
    send_req(MODE_FREE,  12'd0);
    send_req(MODE_ALLOC, 12'h000);
    wait_results_drained();

    // above the maximum clamps to sixteen groups
    write_groups(5'd31);
    send_req(MODE_FREE,  12'hFFF);
    send_req(MODE_ALLOC, 12'h000);
    wait_results_drained();

    // Random: one group filled until nothing is free, then drained a little so
    // that the full group rejoins the queue
    write_groups(5'd1);
    while (sb.free_total != 0) begin
      rand_item(92);
      if (items_sent == 120) hold_request = 1'b1;
      if (items_sent == 200) wait_results_drained();
    end
    repeat (20) rand_item(50);
    wait_results_drained();

    write_groups(5'd2);
    repeat (30) rand_item(75);
    wait_results_drained();

    write_groups(5'($urandom_range(3, 15)));
    repeat (30) rand_item(55);
    wait_results_drained();

    write_groups(5'd16);
    repeat (30) rand_item(45);

    // Drain, then keep the clock running for any stray result before the verdict
    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
